[sv/dcc_pf_pkg.sv]
// ----------------------------------------------------------------------------
// DCC packet framer package
// Request codes, instruction constants and the frame request type shared by
// the framer top level and its frame builder.
// ----------------------------------------------------------------------------
package dcc_pf_pkg;

    localparam int unsigned FRAME_W    = 42;
    localparam int unsigned PREAMBLE_N = 14;
    localparam int unsigned REPEAT_W   = 4;

    typedef enum logic [2:0] {
        OP_IDLE  = 3'd0,
        OP_DRIVE = 3'd1,
        OP_HALT  = 3'd2,
        OP_ESTOP = 3'd3,
        OP_LIGHT = 3'd4
    } t_opcode;

    localparam logic [7:0] IDLE_ADDR       = 8'hFF;
    localparam logic [7:0] IDLE_INSTR      = 8'h00;
    localparam logic [7:0] DRIVE_BASE      = 8'h40;
    localparam logic [7:0] HALT_INSTR      = 8'h60;
    localparam logic [7:0] ESTOP_INSTR     = 8'h61;
    localparam logic [7:0] LIGHT_ON_INSTR  = 8'h90;
    localparam logic [7:0] LIGHT_OFF_INSTR = 8'h80;
    localparam logic [REPEAT_W-1:0] ESTOP_REPEATS_RST = 4'd5;

    typedef struct packed {
        logic                valid;
        logic [FRAME_W-1:0]  frame;
        logic [REPEAT_W-1:0] extra;
    } t_frame_req;

endpackage

[sv/dcc_pf_frame_builder.sv]
// ----------------------------------------------------------------------------
// DCC frame builder
// Decodes one registered request into its instruction byte, packs the 42-bit
// track frame and gives the number of extra repeats that follow the first.
// ----------------------------------------------------------------------------
module dcc_pf_frame_builder (
    input  logic [2:0]                      i_opcode,
    input  logic [7:0]                      i_loco_address,
    input  logic                            i_forward,
    input  logic [4:0]                      i_speed_step,
    input  logic                            i_light_on,
    input  logic [dcc_pf_pkg::REPEAT_W-1:0] i_estop_repeats,
    output dcc_pf_pkg::t_frame_req          o_req
);

    logic [7:0]                      addr;
    logic [7:0]                      instr;
    logic                            op_ok;
    logic [dcc_pf_pkg::REPEAT_W-1:0] extra;

    always_comb begin
        addr  = i_loco_address;
        instr = dcc_pf_pkg::IDLE_INSTR;
        op_ok = 1'b1;
        extra = '0;
        unique case (i_opcode)
            dcc_pf_pkg::OP_IDLE: begin
                addr  = dcc_pf_pkg::IDLE_ADDR;
                instr = dcc_pf_pkg::IDLE_INSTR;
            end
            dcc_pf_pkg::OP_DRIVE: begin
                instr = dcc_pf_pkg::DRIVE_BASE | {2'b00, i_forward, i_speed_step};
            end
            dcc_pf_pkg::OP_HALT: begin
                instr = dcc_pf_pkg::HALT_INSTR;
            end
            dcc_pf_pkg::OP_ESTOP: begin
                instr = dcc_pf_pkg::ESTOP_INSTR;
                if (i_estop_repeats != '0) begin
                    extra = i_estop_repeats - 1'b1;
                end
            end
            dcc_pf_pkg::OP_LIGHT: begin
                instr = i_light_on ? dcc_pf_pkg::LIGHT_ON_INSTR
                                   : dcc_pf_pkg::LIGHT_OFF_INSTR;
            end
            default: begin
                op_ok = 1'b0;
            end
        endcase
    end

    assign o_req.valid = op_ok;
    assign o_req.extra = extra;
    assign o_req.frame = {{dcc_pf_pkg::PREAMBLE_N{1'b1}}, 1'b0, addr, 1'b0, instr,
                          1'b0, addr ^ instr, 1'b1};

endmodule

[sv/dcc_packet_framer_unit.sv]
// ----------------------------------------------------------------------------
// DCC packet framer unit
// Turns locomotive requests into complete 42-bit DCC baseline track frames.
// ----------------------------------------------------------------------------
// A request is taken at each clock edge where start is high and busy is low;
// its frame passes the input and result registers to o_frame_bits with
// o_valid; bit 41 is the first bit on the wire. Every request except an
// emergency stop gives one beat, so requests may follow each other in every
// cycle while busy is low. An emergency stop gives estop_repeats beats (a count
// of zero counts as one) in consecutive cycles, and o_last marks the final
// beat; while those repeats go out from the result register, busy stays high
// once the next request waits in the input register. Unused request codes
// give no beat. Each beat is valid for exactly one cycle and must be taken then.
module dcc_packet_framer_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [2:0]                         i_opcode,
    input  logic [7:0]                         i_loco_address,
    input  logic                               i_forward,
    input  logic [4:0]                         i_speed_step,
    input  logic                               i_light_on,
    input  logic                               i_cfg_wr_en,
    input  logic [dcc_pf_pkg::REPEAT_W-1:0]    i_cfg_wr_data,
    output logic                               o_valid,
    output logic [dcc_pf_pkg::FRAME_W-1:0]     o_frame_bits,
    output logic                               o_last
);

    logic [dcc_pf_pkg::REPEAT_W-1:0] r_estop_repeats;

    logic       r_in_valid;
    logic [2:0] r_opcode;
    logic [7:0] r_loco_address;
    logic       r_forward;
    logic [4:0] r_speed_step;
    logic       r_light_on;

    logic                            r_out_valid;
    logic [dcc_pf_pkg::FRAME_W-1:0]  r_frame;
    logic [dcc_pf_pkg::REPEAT_W-1:0] r_left;

    dcc_pf_pkg::t_frame_req req;
    logic                   out_free;
    logic                   accept;

    dcc_pf_frame_builder u_builder (
        .i_opcode        (r_opcode),
        .i_loco_address  (r_loco_address),
        .i_forward       (r_forward),
        .i_speed_step    (r_speed_step),
        .i_light_on      (r_light_on),
        .i_estop_repeats (r_estop_repeats),
        .o_req           (req)
    );

    assign out_free = !r_out_valid || (r_left == '0);
    assign busy     = r_in_valid && !out_free;
    assign accept   = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_estop_repeats <= dcc_pf_pkg::ESTOP_REPEATS_RST;
        end else if (i_cfg_wr_en) begin
            r_estop_repeats <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (out_free) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_opcode       <= i_opcode;
            r_loco_address <= i_loco_address;
            r_forward      <= i_forward;
            r_speed_step   <= i_speed_step;
            r_light_on     <= i_light_on;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_left      <= '0;
        end else if (r_out_valid && (r_left != '0)) begin
            r_left <= r_left - 1'b1;
        end else if (r_in_valid && req.valid) begin
            r_out_valid <= 1'b1;
            r_left      <= req.extra;
        end else begin
            r_out_valid <= 1'b0;
            r_left      <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_in_valid && req.valid) begin
            r_frame <= req.frame;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_frame_bits = r_frame;
    assign o_last       = (r_left == '0);

    a_repeat_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> o_valid)
        else $error("Repeat beat missing before the last beat.");

    a_repeat_same_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> $stable(o_frame_bits))
        else $error("Frame changed between repeat beats.");

    a_busy_only_repeating: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_out_valid && (r_left != '0) && r_in_valid))
        else $error("Busy raised without pending repeats.");

    a_left_counts_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_left != '0)) |=> (r_left == $past(r_left) - 1'b1))
        else $error("Repeat counter did not count down.");

endmodule
